@@ rtl/core/cpu8alu_pkg.sv @@
// ----------------------------------------------------------------------------
// cpu8alu_pkg: shared types and constants of the eight-bit ALU
// Command codes, the per-beat input and result records, and the constants
// that the decimal adjust logic uses.
// ----------------------------------------------------------------------------
package cpu8alu_pkg;

    // Operation codes carried by the command field.
    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_AND  = 4'd2,
        CMD_OR   = 4'd3,
        CMD_XOR  = 4'd4,
        CMD_SHL  = 4'd5,
        CMD_SHR  = 4'd6,
        CMD_ROTL = 4'd7,
        CMD_ROTR = 4'd8,
        CMD_INC  = 4'd9,
        CMD_DEC  = 4'd10,
        CMD_CMP  = 4'd11,
        CMD_BIT  = 4'd12,
        CMD_LOAD = 4'd13
    } t_cmd;

    // Decimal adjust constants.
    localparam logic [4:0] BCD_LO_LIMIT = 5'h0A;
    localparam logic [3:0] BCD_LO_ADJ   = 4'h6;
    localparam logic [3:0] BCD_LO_WRAP  = 4'hA;
    localparam logic [8:0] BCD_HI_LIMIT = 9'h0A0;
    localparam logic [9:0] BCD_HI_ADJ   = 10'h060;
    localparam logic [7:0] BCD_HI_SUB   = 8'h60;

    // One input beat.
    typedef struct packed {
        logic [3:0] command;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic       carry_in;
        logic       overflow_in;
        logic       decimal_in;
    } t_item;

    // Result of the adder / subtractor.
    typedef struct packed {
        logic [7:0] value;
        logic       carry;
        logic       overflow;
    } t_arith;

    // One result beat.
    typedef struct packed {
        logic [7:0] result_byte;
        logic       carry_out;
        logic       zero_out;
        logic       negative_out;
        logic       overflow_out;
    } t_result;

endpackage

@@ rtl/core/cpu8alu_addsub.sv @@
// ----------------------------------------------------------------------------
// cpu8alu_addsub: binary and decimal add / subtract with carry
// Computes a+b+c or a-b-(1-c), with nibble decimal adjust when decimal mode
// is on, and returns the byte, the carry (no borrow on subtract) and the
// signed overflow taken from the final byte.
// ----------------------------------------------------------------------------
module cpu8alu_addsub (
    input  logic [7:0]           i_a,
    input  logic [7:0]           i_b,
    input  logic                 i_carry,
    input  logic                 i_decimal,
    input  logic                 i_sub,
    output cpu8alu_pkg::t_arith  o_arith
);

    logic [4:0] add_lo_raw;
    logic [4:0] add_lo;
    logic [8:0] add_hi;
    logic [9:0] add_dec;
    logic [8:0] add_bin;
    logic       borrow;
    logic [5:0] sub_lo_raw;
    logic [5:0] sub_lo;
    logic [9:0] sub_dec;
    logic [8:0] sub_bin;
    logic [7:0] add_r;
    logic [7:0] sub_r;
    logic       add_c;
    logic       sub_c;

    // Decimal add: the low digit carries 0x10 into the high part after adjust.
    assign add_lo_raw = {1'b0, i_a[3:0]} + {1'b0, i_b[3:0]} + {4'b0, i_carry};
    assign add_lo     = (add_lo_raw >= cpu8alu_pkg::BCD_LO_LIMIT)
                      ? {1'b1, add_lo_raw[3:0] + cpu8alu_pkg::BCD_LO_ADJ} : add_lo_raw;
    assign add_hi     = {1'b0, i_a[7:4], 4'b0} + {1'b0, i_b[7:4], 4'b0} + {4'b0, add_lo};
    assign add_dec    = (add_hi >= cpu8alu_pkg::BCD_HI_LIMIT)
                      ? ({1'b0, add_hi} + cpu8alu_pkg::BCD_HI_ADJ) : {1'b0, add_hi};
    assign add_bin    = {1'b0, i_a} + {1'b0, i_b} + {8'b0, i_carry};

    // Decimal subtract: a negative low digit wraps into the range -16 to -1.
    assign borrow     = ~i_carry;
    assign sub_lo_raw = {2'b0, i_a[3:0]} - {2'b0, i_b[3:0]} - {5'b0, borrow};
    assign sub_lo     = sub_lo_raw[5]
                      ? {2'b11, sub_lo_raw[3:0] + cpu8alu_pkg::BCD_LO_WRAP} : sub_lo_raw;
    assign sub_dec    = {2'b0, i_a[7:4], 4'b0} - {2'b0, i_b[7:4], 4'b0}
                      + {{4{sub_lo[5]}}, sub_lo};
    assign sub_bin    = {1'b0, i_a} - {1'b0, i_b} - {8'b0, borrow};

    // Pick the mode and form the byte and carry.
    always_comb begin
        if (i_decimal) begin
            add_r = add_dec[7:0];
            add_c = |add_dec[9:8];
            sub_r = sub_dec[9] ? (sub_dec[7:0] - cpu8alu_pkg::BCD_HI_SUB) : sub_dec[7:0];
            sub_c = ~sub_dec[9];
        end else begin
            add_r = add_bin[7:0];
            add_c = add_bin[8];
            sub_r = sub_bin[7:0];
            sub_c = ~sub_bin[8];
        end
    end

    // Overflow is taken from the final byte in both modes.
    always_comb begin
        if (i_sub) begin
            o_arith.value    = sub_r;
            o_arith.carry    = sub_c;
            o_arith.overflow = (i_a[7] ^ sub_r[7]) & (~i_b[7] ^ sub_r[7]);
        end else begin
            o_arith.value    = add_r;
            o_arith.carry    = add_c;
            o_arith.overflow = (i_a[7] ^ add_r[7]) & (i_b[7] ^ add_r[7]);
        end
    end

endmodule

@@ rtl/core/cpu8alu_exec.sv @@
// ----------------------------------------------------------------------------
// cpu8alu_exec: operation decode, result select and flag update
// Combinational path between the input register and the result register.
// Flags that an operation leaves alone pass through from the input beat.
// ----------------------------------------------------------------------------
module cpu8alu_exec (
    input  cpu8alu_pkg::t_item   i_item,
    output cpu8alu_pkg::t_result o_result
);

    cpu8alu_pkg::t_arith arith;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] cmp_diff;
    logic [7:0] r;
    logic       c;
    logic       v;
    logic       z;
    logic       n;
    logic       zn_from_r;

    assign a        = i_item.operand_a;
    assign b        = i_item.operand_b;
    assign cmp_diff = a - b;

    // Shared adder for add and subtract.
    cpu8alu_addsub u_addsub (
        .i_a       (a),
        .i_b       (b),
        .i_carry   (i_item.carry_in),
        .i_decimal (i_item.decimal_in),
        .i_sub     (cpu8alu_pkg::t_cmd'(i_item.command) == cpu8alu_pkg::CMD_SUB),
        .o_arith   (arith)
    );

    // Decode the command and select result and flags.
    always_comb begin
        r         = a;
        c         = i_item.carry_in;
        v         = i_item.overflow_in;
        z         = 1'b0;
        n         = 1'b0;
        zn_from_r = 1'b1;
        unique case (cpu8alu_pkg::t_cmd'(i_item.command)) inside
            cpu8alu_pkg::CMD_ADD, cpu8alu_pkg::CMD_SUB: begin
                r = arith.value;
                c = arith.carry;
                v = arith.overflow;
            end
            cpu8alu_pkg::CMD_AND:  r = a & b;
            cpu8alu_pkg::CMD_OR:   r = a | b;
            cpu8alu_pkg::CMD_XOR:  r = a ^ b;
            cpu8alu_pkg::CMD_SHL: begin
                c = a[7];
                r = {a[6:0], 1'b0};
            end
            cpu8alu_pkg::CMD_SHR: begin
                c = a[0];
                r = {1'b0, a[7:1]};
            end
            cpu8alu_pkg::CMD_ROTL: begin
                c = a[7];
                r = {a[6:0], i_item.carry_in};
            end
            cpu8alu_pkg::CMD_ROTR: begin
                c = a[0];
                r = {i_item.carry_in, a[7:1]};
            end
            cpu8alu_pkg::CMD_INC:  r = a + 8'd1;
            cpu8alu_pkg::CMD_DEC:  r = a - 8'd1;
            cpu8alu_pkg::CMD_CMP: begin
                c         = (a >= b);
                z         = (a == b);
                n         = cmp_diff[7];
                zn_from_r = 1'b0;
            end
            cpu8alu_pkg::CMD_BIT: begin
                z         = ((a & b) == 8'h00);
                n         = b[7];
                v         = b[6];
                zn_from_r = 1'b0;
            end
            cpu8alu_pkg::CMD_LOAD: r = b;
            default:               r = a;
        endcase
        if (zn_from_r) begin
            z = (r == 8'h00);
            n = r[7];
        end
    end

    assign o_result.result_byte  = r;
    assign o_result.carry_out    = c;
    assign o_result.zero_out     = z;
    assign o_result.negative_out = n;
    assign o_result.overflow_out = v;

endmodule

@@ rtl/core/cpu8_alu_bcd_flags_top.sv @@
// ----------------------------------------------------------------------------
// cpu8_alu_bcd_flags_top: eight-bit processor ALU with decimal mode
//
//   Channel   Handshake          Fields
//   command   start / busy       i_command, i_operand_a, i_operand_b,
//                                i_carry_in, i_overflow_in, i_decimal_in
//   result    o_valid (strobe)   o_result_byte, o_carry_out, o_zero_out,
//                                o_negative_out, o_overflow_out
//
// One beat is accepted in every cycle; busy is always low.
// Each command beat passes through the input register and then the result
// register, with the decode and adder logic between them.
// Reset is synchronous and active low; it clears both valid bits.
// The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module cpu8_alu_bcd_flags_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] i_command,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic       i_carry_in,
    input  logic       i_overflow_in,
    input  logic       i_decimal_in,
    output logic       o_valid,
    output logic [7:0] o_result_byte,
    output logic       o_carry_out,
    output logic       o_zero_out,
    output logic       o_negative_out,
    output logic       o_overflow_out
);

    logic                 r_in_vld;
    cpu8alu_pkg::t_item   r_item;
    cpu8alu_pkg::t_item   n_item;
    logic                 r_out_vld;
    cpu8alu_pkg::t_result r_res;
    cpu8alu_pkg::t_result n_res;

    // The block never holds off a command beat.
    assign busy = 1'b0;

    assign n_item.command     = i_command;
    assign n_item.operand_a   = i_operand_a;
    assign n_item.operand_b   = i_operand_b;
    assign n_item.carry_in    = i_carry_in;
    assign n_item.overflow_in = i_overflow_in;
    assign n_item.decimal_in  = i_decimal_in;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start & ~busy;
        end
        r_item <= n_item;
    end

    // Execute logic.
    cpu8alu_exec u_exec (
        .i_item   (r_item),
        .o_result (n_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        r_res <= n_res;
    end

    assign o_valid        = r_out_vld;
    assign o_result_byte  = r_res.result_byte;
    assign o_carry_out    = r_res.carry_out;
    assign o_zero_out     = r_res.zero_out;
    assign o_negative_out = r_res.negative_out;
    assign o_overflow_out = r_res.overflow_out;

    // Every accepted beat yields a result.
    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted beat produced no result");

    // No result appears without an earlier accepted beat.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result without an accepted beat");

    // Compare leaves the register operand in the result byte.
    a_cmp_keeps_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_command == cpu8alu_pkg::CMD_CMP) |=> ##1
        (o_result_byte == $past(i_operand_a, 2)))
        else $error("compare changed the result byte");

    // Load takes zero from the loaded byte.
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_command == cpu8alu_pkg::CMD_LOAD) |=> ##1
        (o_zero_out == (o_result_byte == 8'h00)))
        else $error("load zero flag does not match the result");

endmodule

@@ verif/cpu8_alu_bcd_flags_top_tb.sv @@
// ----------------------------------------------------------------------------
// cpu8_alu_bcd_flags_top_tb: self-checking bench for the eight-bit ALU
// Drives directed corner beats and then random beats through the command
// port. A scoreboard predicts each result from the accepted beat and checks
// every result strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module cpu8_alu_bcd_flags_top_tb;

    // Command codes that the ALU does not decode; they pass the register operand through.
    localparam logic [3:0] CMD_SPARE_LO = 4'd14;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;

    localparam int RANDOM_BEATS = 1500;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 100000;

    // Scoreboard: predicts the ALU result for each accepted beat and checks
    // result strobes in order.
    class alu_scoreboard;
        cpu8alu_pkg::t_result pending[$];
        int                   mismatches;
        int                   results_checked;

        function new();
            mismatches      = 0;
            results_checked = 0;
        endfunction

        // Result byte and flags that the ALU produces for one beat.
        function cpu8alu_pkg::t_result predict_alu(cpu8alu_pkg::t_item it);
            int      a, b, cin, sum, lo, diff;
            logic [7:0] r;
            logic    c, v, z, n;
            bit      zn_from_r;
            cpu8alu_pkg::t_result res;
            a = int'(it.operand_a);
            b = int'(it.operand_b);
            cin = int'(it.carry_in);
            r = it.operand_a;
            c = it.carry_in;
            v = it.overflow_in;
            z = 1'b0;
            n = 1'b0;
            zn_from_r = 1'b1;
            case (it.command)
                cpu8alu_pkg::CMD_ADD: begin
                    if (it.decimal_in) begin
                        // Low digit adjust carries 0x10 into the high part.
                        lo = (a & 'h0F) + (b & 'h0F) + cin;
                        if (lo >= 'h0A) lo = ((lo + 'h06) & 'h0F) + 'h10;
                        sum = (a & 'hF0) + (b & 'hF0) + lo;
                        if (sum >= 'hA0) sum += 'h60;
                    end else begin
                        sum = a + b + cin;
                    end
                    r = sum[7:0];
                    c = (sum > 'hFF);
                    v = (((a ^ r) & (b ^ r) & 'h80) != 0);
                end
                cpu8alu_pkg::CMD_SUB: begin
                    if (it.decimal_in) begin
                        // A negative low digit borrows 0x10 from the high part.
                        lo = (a & 'h0F) - (b & 'h0F) - (1 - cin);
                        if (lo < 0) lo = ((lo + 26) & 'h0F) - 'h10;
                        diff = (a & 'hF0) - (b & 'hF0) + lo;
                        if (diff < 0) diff -= 'h60;
                    end else begin
                        diff = a - b - (1 - cin);
                    end
                    r = 8'((diff + 512) & 'hFF);
                    c = (diff >= 0);
                    v = (((a ^ r) & ((~b & 'hFF) ^ r) & 'h80) != 0);
                end
                cpu8alu_pkg::CMD_AND:  r = it.operand_a & it.operand_b;
                cpu8alu_pkg::CMD_OR:   r = it.operand_a | it.operand_b;
                cpu8alu_pkg::CMD_XOR:  r = it.operand_a ^ it.operand_b;
                cpu8alu_pkg::CMD_SHL: begin
                    c = it.operand_a[7];
                    r = {it.operand_a[6:0], 1'b0};
                end
                cpu8alu_pkg::CMD_SHR: begin
                    c = it.operand_a[0];
                    r = {1'b0, it.operand_a[7:1]};
                end
                cpu8alu_pkg::CMD_ROTL: begin
                    c = it.operand_a[7];
                    r = {it.operand_a[6:0], it.carry_in};
                end
                cpu8alu_pkg::CMD_ROTR: begin
                    c = it.operand_a[0];
                    r = {it.carry_in, it.operand_a[7:1]};
                end
                cpu8alu_pkg::CMD_INC:  r = it.operand_a + 8'd1;
                cpu8alu_pkg::CMD_DEC:  r = it.operand_a - 8'd1;
                cpu8alu_pkg::CMD_CMP: begin
                    c = (a >= b);
                    z = (a == b);
                    n = ((a - b) & 'h80) != 0;
                    zn_from_r = 1'b0;
                end
                cpu8alu_pkg::CMD_BIT: begin
                    z = ((it.operand_a & it.operand_b) == 8'h00);
                    n = it.operand_b[7];
                    v = it.operand_b[6];
                    zn_from_r = 1'b0;
                end
                cpu8alu_pkg::CMD_LOAD: r = it.operand_b;
                default:  r = it.operand_a;
            endcase
            if (zn_from_r) begin
                z = (r == 8'h00);
                n = r[7];
            end
            res.result_byte  = r;
            res.carry_out    = c;
            res.zero_out     = z;
            res.negative_out = n;
            res.overflow_out = v;
            return res;
        endfunction

        // Records the prediction for one accepted command beat.
        function void note_command(cpu8alu_pkg::t_item it);
            pending.push_back(predict_alu(it));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Checks one result beat against the oldest prediction.
        function void check_result(cpu8alu_pkg::t_result got);
            cpu8alu_pkg::t_result want;
            if (pending.size() == 0) begin
                $error("result beat with no command outstanding: 0x%0h", got);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            results_checked++;
            compare_field("result_byte", want.result_byte, got.result_byte);
            compare_field("carry_out", 8'(want.carry_out), 8'(got.carry_out));
            compare_field("zero_out", 8'(want.zero_out), 8'(got.zero_out));
            compare_field("negative_out", 8'(want.negative_out),
                          8'(got.negative_out));
            compare_field("overflow_out", 8'(want.overflow_out),
                          8'(got.overflow_out));
        endfunction
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       start         = 1'b0;
    logic [3:0] i_command     = '0;
    logic [7:0] i_operand_a   = '0;
    logic [7:0] i_operand_b   = '0;
    logic       i_carry_in    = 1'b0;
    logic       i_overflow_in = 1'b0;
    logic       i_decimal_in  = 1'b0;
    logic       busy;
    logic       o_valid;
    logic [7:0] o_result_byte;
    logic       o_carry_out;
    logic       o_zero_out;
    logic       o_negative_out;
    logic       o_overflow_out;

    alu_scoreboard sb = new();
    int cycle_count   = 0;
    int sender_idle_pct;
    int beats_per_cmd[16];
    int decimal_beats = 0;

    cpu8_alu_bcd_flags_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_carry_in    (i_carry_in),
        .i_overflow_in (i_overflow_in),
        .i_decimal_in  (i_decimal_in),
        .o_valid       (o_valid),
        .o_result_byte (o_result_byte),
        .o_carry_out   (o_carry_out),
        .o_zero_out    (o_zero_out),
        .o_negative_out(o_negative_out),
        .o_overflow_out(o_overflow_out)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Monitor: records accepted command beats and checks result beats.
    always @(posedge i_clk) begin
        cpu8alu_pkg::t_item   seen;
        cpu8alu_pkg::t_result got;
        if (i_rst_n) begin
            if (start && !busy) begin
                seen = '{i_command, i_operand_a, i_operand_b,
                         i_carry_in, i_overflow_in, i_decimal_in};
                sb.note_command(seen);
                beats_per_cmd[i_command]++;
                if (i_decimal_in && (i_command == cpu8alu_pkg::CMD_ADD ||
                                     i_command == cpu8alu_pkg::CMD_SUB))
                    decimal_beats++;
            end
            if (o_valid === 1'b1) begin
                got = '{o_result_byte, o_carry_out, o_zero_out,
                        o_negative_out, o_overflow_out};
                sb.check_result(got);
            end
        end
    end

    // Presents one beat and holds it until the ALU takes it, then idles the
    // command port at random for the current sender idle rate.
    task automatic send_beat(input logic [3:0] cmd, input logic [7:0] a,
                             input logic [7:0] b, input logic c,
                             input logic v, input logic d);
        start         <= 1'b1;
        i_command     <= cmd;
        i_operand_a   <= a;
        i_operand_b   <= b;
        i_carry_in    <= c;
        i_overflow_in <= v;
        i_decimal_in  <= d;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < sender_idle_pct);
        end
    endtask

    // Operand byte drawn from corners, packed BCD or the full range.
    function automatic logic [7:0] pick_operand();
        logic [7:0] corners[6] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h01, 8'h99};
        int sel;
        sel = $urandom_range(0, 3);
        if (sel == 0) return corners[$urandom_range(0, 5)];
        if (sel == 1) return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_beat();
        logic [3:0] cmd;
        // Add and subtract carry the decimal logic, so they get extra weight.
        if ($urandom_range(0, 99) < 40)
            cmd = $urandom_range(0, 1) ? cpu8alu_pkg::CMD_SUB : cpu8alu_pkg::CMD_ADD;
        else
            cmd = 4'($urandom_range(0, 15));
        send_beat(cmd, pick_operand(), pick_operand(), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int total_beats;
        sender_idle_pct = 23;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: binary and decimal carries, borrows and overflow.
        send_beat(cpu8alu_pkg::CMD_ADD, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0);
        send_beat(cpu8alu_pkg::CMD_ADD, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_ADD, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_ADD, 8'h99, 8'h01, 1'b0, 1'b0, 1'b1);
        send_beat(cpu8alu_pkg::CMD_ADD, 8'h09, 8'h01, 1'b1, 1'b0, 1'b1);
        send_beat(cpu8alu_pkg::CMD_ADD, 8'h58, 8'h46, 1'b1, 1'b0, 1'b1);
        send_beat(cpu8alu_pkg::CMD_SUB, 8'h00, 8'h01, 1'b1, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_SUB, 8'h80, 8'h01, 1'b1, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_SUB, 8'h05, 8'h05, 1'b0, 1'b1, 1'b0);
        send_beat(cpu8alu_pkg::CMD_SUB, 8'h00, 8'h01, 1'b1, 1'b0, 1'b1);
        send_beat(cpu8alu_pkg::CMD_SUB, 8'h10, 8'h01, 1'b1, 1'b0, 1'b1);
        // Logic, shifts and rotates with the carry shifted in and out; increment, decrement.
        send_beat(cpu8alu_pkg::CMD_AND, 8'hFF, 8'h00, 1'b1, 1'b1, 1'b0);
        send_beat(cpu8alu_pkg::CMD_OR, 8'h80, 8'h01, 1'b0, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_XOR, 8'hAA, 8'h55, 1'b0, 1'b1, 1'b1);
        send_beat(cpu8alu_pkg::CMD_SHL, 8'h81, 8'h00, 1'b0, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_SHR, 8'h01, 8'h00, 1'b0, 1'b1, 1'b0);
        send_beat(cpu8alu_pkg::CMD_ROTL, 8'h80, 8'h00, 1'b1, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_ROTR, 8'h01, 8'h00, 1'b1, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_INC, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_DEC, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
        // Compare carries on register at least operand; bit test flags; load.
        send_beat(cpu8alu_pkg::CMD_CMP, 8'h10, 8'h10, 1'b0, 1'b1, 1'b0);
        send_beat(cpu8alu_pkg::CMD_CMP, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_CMP, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_BIT, 8'h0F, 8'hC0, 1'b1, 1'b0, 1'b0);
        send_beat(cpu8alu_pkg::CMD_LOAD, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0);
        // Unused codes pass the register operand through.
        send_beat(CMD_SPARE_LO, 8'h80, 8'h12, 1'b1, 1'b1, 1'b1);
        send_beat(CMD_SPARE_HI, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0);

        // Random beats in three pacing phases: light, heavy, then back to back.
        repeat (RANDOM_BEATS / 3) send_random_beat();
        sender_idle_pct = 48;
        repeat (RANDOM_BEATS / 3) send_random_beat();
        sender_idle_pct = 0;
        repeat (RANDOM_BEATS / 3) send_random_beat();
        start <= 1'b0;

        // Drain outstanding results, then allow for late extra strobes.
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        total_beats = 0;
        foreach (beats_per_cmd[k]) total_beats += beats_per_cmd[k];
        $display("Ran %0d command beats over all 16 codes, %0d of them decimal add/sub.",
                 total_beats, decimal_beats);
        $display("Checked %0d result beats under three pacing phases.",
                 sb.results_checked);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
